// ----- rtl/kbdev_pkg.sv -----
// Shared types and constants for the keyboard report to key event block.
`default_nettype none
package kbdev_pkg;

   localparam int DEVICES     = 4;
   localparam int SLOTS       = 6;
   localparam int MOD_BITS    = 8;
   localparam int EVENTS      = MOD_BITS + 2 * SLOTS;
   localparam int DEV_IDX_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam logic [7:0] MOD_BASE = 8'hE0;

   typedef struct packed {
      logic [1:0] device;
      logic [7:0] modifier_bits;
      logic [7:0] slot0;
      logic [7:0] slot1;
      logic [7:0] slot2;
      logic [7:0] slot3;
      logic [7:0] slot4;
      logic [7:0] slot5;
   } req_type;

   typedef struct packed {
      logic [7:0] keycode;
      logic       pressed;
      logic       last_event;
   } rsp_type;

   typedef logic [SLOTS-1:0][7:0] slots_type;

   // Pending events of one report: bit order is modifiers, breaks, makes.
   typedef struct packed {
      logic [EVENTS-1:0] mask;
      logic [7:0]        mods;
      slots_type         old_slots;
      slots_type         new_slots;
   } diff_type;

endpackage
`default_nettype wire

// ----- rtl/kbdev_diff.sv -----
// Compares a report against the stored report and flags every key event.
`default_nettype none
module kbdev_diff (
   input  wire logic               enable,
   input  wire logic [7:0]         new_mods,
   input  wire kbdev_pkg::slots_type new_slots,
   input  wire logic [7:0]         old_mods,
   input  wire kbdev_pkg::slots_type old_slots,
   output kbdev_pkg::diff_type     diff
);
   import kbdev_pkg::*;

   always_comb begin
      logic seen;
      diff.mods      = new_mods;
      diff.old_slots = old_slots;
      diff.new_slots = new_slots;
      diff.mask      = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         diff.mask[i] = enable && (new_mods[i] != old_mods[i]);
      end
      // breaks: old key absent from new report
      for (int i = 0; i < SLOTS; i++) begin
         seen = 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            seen = seen | (new_slots[j] == old_slots[i]);
         end
         diff.mask[MOD_BITS + i] = enable && (old_slots[i] != 8'd0) && !seen;
      end
      // makes: new key absent from old report
      for (int i = 0; i < SLOTS; i++) begin
         seen = 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            seen = seen | (old_slots[j] == new_slots[i]);
         end
         diff.mask[MOD_BITS + SLOTS + i] = enable && (new_slots[i] != 8'd0) && !seen;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/keyboard_report_to_key_events.sv -----
// Top level: per-device keyboard report differ with a one-event-per-cycle emitter
//   that rsp_stall can hold. First event of a request passes the event buffer and
//   then the result register before it shows on rsp. Up to 20 events per request,
//   drained from the single event buffer one flagged event at a time.
// Requests that cause no event produce nothing.
// Reset: synchronous, clears all devices' stored report, the event buffer and rsp_valid.
`default_nettype none
module keyboard_report_to_key_events (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire kbdev_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output kbdev_pkg::rsp_type      rsp_data
);
   import kbdev_pkg::*;

   // per-device stored report
   logic [7:0] prev_mods_ff  [DEVICES];
   slots_type  prev_slots_ff [DEVICES];

   // event buffer for the request being drained
   logic [EVENTS-1:0] buf_mask_ff, buf_mask_in;
   logic [7:0]        buf_mods_ff;
   slots_type         buf_old_ff, buf_new_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                 req_acc, dev_ok, pop, pop_last, buf_has;
   logic [DEV_IDX_W-1:0] dev_idx;
   slots_type            cur_slots;
   diff_type             diff;
   logic [EVENTS-1:0]    sel, rest;

   assign dev_idx = req_data.device[DEV_IDX_W-1:0];
   assign dev_ok  = 32'(req_data.device) < DEVICES;

   // slot fields beyond SLOTS are ignored
   always_comb begin
      slots_type all_slots;
      logic [5:0][7:0] fields;
      fields = {req_data.slot5, req_data.slot4, req_data.slot3,
                req_data.slot2, req_data.slot1, req_data.slot0};
      all_slots = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (i < 6) begin
            all_slots[i] = fields[i];
         end
      end
      cur_slots = all_slots;
   end

   kbdev_diff u_diff (
      .enable    (dev_ok),
      .new_mods  (req_data.modifier_bits),
      .new_slots (cur_slots),
      .old_mods  (prev_mods_ff[dev_idx]),
      .old_slots (prev_slots_ff[dev_idx]),
      .diff      (diff)
   );

   // pick lowest flagged event; it is the last one if nothing is left after it
   assign buf_has  = |buf_mask_ff;
   assign sel      = buf_mask_ff & (~buf_mask_ff + EVENTS'(1));
   assign rest     = buf_mask_ff & ~sel;
   assign pop_last = (rest == '0);
   assign pop      = buf_has && (!rsp_valid_ff || !rsp_stall);

   // take a new request once the buffer is empty or hands off its last event now
   assign req_stall = buf_has && !(pop && pop_last);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      logic [7:0] code;
      logic       lvl;
      code = '0;
      lvl  = 1'b0;
      for (int k = 0; k < MOD_BITS; k++) begin
         if (sel[k]) begin
            code = code | (MOD_BASE + 8'(k));
            lvl  = lvl | buf_mods_ff[k];
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (sel[MOD_BITS + k]) begin
            code = code | buf_old_ff[k];
         end
         if (sel[MOD_BITS + SLOTS + k]) begin
            code = code | buf_new_ff[k];
            lvl  = 1'b1;
         end
      end
      rsp_data_in.keycode    = code;
      rsp_data_in.pressed    = lvl;
      rsp_data_in.last_event = pop_last;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      buf_mask_in = buf_mask_ff;
      if (req_acc) begin
         buf_mask_in = diff.mask;
      end else if (pop) begin
         buf_mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         buf_mask_ff  <= '0;
         for (int d = 0; d < DEVICES; d++) begin
            prev_mods_ff[d]  <= '0;
            prev_slots_ff[d] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         buf_mask_ff  <= buf_mask_in;
         if (req_acc && dev_ok) begin
            prev_mods_ff[dev_idx]  <= req_data.modifier_bits;
            prev_slots_ff[dev_idx] <= cur_slots;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (req_acc) begin
         buf_mods_ff <= diff.mods;
         buf_old_ff  <= diff.old_slots;
         buf_new_ff  <= diff.new_slots;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // final event of a report leaves the buffer empty unless a new request came in
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_last && !req_acc) |=> (buf_mask_ff == '0))
      else $error("buffer not empty after final event");

   // an event that is not last leaves more work behind
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (pop && !pop_last) |=> buf_has)
      else $error("events lost after non-final event");

   // no output appears without a buffered event
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!buf_has && !(rsp_valid_ff && rsp_stall)) |=> !rsp_valid_ff)
      else $error("result without pending event");

endmodule
`default_nettype wire
